// ===== rtl/core/nbfm_pkg.sv =====
`timescale 1ns / 1ps
package nbfm_pkg;

   localparam int SampleWidth = 16;
   localparam int CordicSteps = 30;
   localparam int FracBits    = 32 - SampleWidth;

   typedef enum logic [3:0] {
      S_IDLE, S_RE, S_IM, S_INIT, S_ROT, S_SCALE, S_Y, S_YF, S_FB_B, S_FB_A, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_RE, OP_IM, OP_INIT, OP_ROT, OP_SCALE, OP_Y, OP_YF,
      OP_FB_B, OP_FB_A, OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] idx;
   } cmd_type;

   function automatic logic [31:0] atan_lut(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051D;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2E;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000028;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000002;
         5'd29: r = 32'h00000001;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] coef_b(input logic [2:0] k);
      logic signed [31:0] r;
      case (k)
         3'd0, 3'd4: r = 32'sd250584;
         3'd1, 3'd3: r = 32'sd1002337;
         3'd2:       r = 32'sd1503505;
         default:    r = 32'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] coef_a(input logic [1:0] k);
      logic signed [31:0] r;
      case (k)
         2'd0:    r = -32'sd799090566;
         2'd1:    r = 32'sd918669219;
         2'd2:    r = -32'sd479454340;
         default: r = 32'sd95449577;
      endcase
      return r;
   endfunction

   // coefficient product rounded by 2^20
   function automatic logic signed [63:0] cmul(input logic signed [31:0] c,
                                               input logic signed [31:0] v);
      logic signed [63:0] p;
      p = 64'(c) * 64'(v);
      return (p + 64'sd524288) >>> 20;
   endfunction

   function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                                input int bits);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

endpackage

// ===== rtl/core/nbfm_discriminator_lowpass.sv =====
`timescale 1ns / 1ps
// One item is processed at a time: req_stall stays high from acceptance until the
// result is written, through the 30-step iterative CORDIC
// plus the eight sequenced delay-line update steps of the filter.
// The next item is taken while the previous result waits to be taken.
// Reset (synchronous): previous sample and filter delay line cleared, no result pending.
module nbfm_discriminator_lowpass (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_in_i,
   input  logic signed [15:0] req_in_q,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_audio_sample
);
   import nbfm_pkg::*;

   cmd_type cmd;

   nbfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   nbfm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_in_i         (req_in_i),
      .req_in_q         (req_in_q),
      .rsp_audio_sample (rsp_audio_sample)
   );

endmodule

// ===== rtl/core/nbfm_datapath.sv =====
`timescale 1ns / 1ps
module nbfm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  nbfm_pkg::cmd_type     cmd,
   input  logic signed [15:0]    req_in_i,
   input  logic signed [15:0]    req_in_q,
   output logic signed [15:0]    rsp_audio_sample
);
   import nbfm_pkg::*;

   logic signed [15:0] xi_ff, xq_ff, pi_ff, pq_ff;
   logic signed [33:0] re_ff, im_ff;
   logic signed [63:0] cx_ff, cy_ff;
   logic [31:0]        cz_ff;
   logic               zero_ff;
   logic signed [31:0] u_ff, yf_ff;
   logic signed [49:0] y_ff;
   logic signed [63:0] t_ff;
   logic signed [47:0] mem_ff [4];
   logic signed [15:0] out_ff;

   logic signed [63:0] xe, ye, xs, ys, scale_p, fb, yv, ov, tail;
   logic signed [32:0] ang;

   always_comb begin
      xe = $signed({re_ff, 30'd0});
      ye = $signed({im_ff, 30'd0});
      xs = cx_ff >>> cmd.idx;
      ys = cy_ff >>> cmd.idx;
      if (zero_ff) begin
         ang = 33'sd0;
      end else if (cz_ff == 32'h8000_0000) begin
         ang = 33'sh0_8000_0000;
      end else begin
         ang = 33'(signed'(cz_ff));
      end
      scale_p = 64'(ang) * 64'sd32767;
      tail = (cmd.idx[1:0] == 2'd3) ? 64'sd0 : 64'(mem_ff[1]);
      fb = sat64(t_ff - cmul(coef_a(cmd.idx[1:0]), yf_ff) + tail, 48);
      yv = sat64((64'(y_ff) + 64'sd128) >>> 8, 32);
      ov = sat64((64'(y_ff) + (64'sd1 <<< (FracBits + 7))) >>> (FracBits + 8), SampleWidth);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pi_ff <= '0;
         pq_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            mem_ff[k] <= '0;
         end
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               xi_ff <= req_in_i;
               xq_ff <= req_in_q;
            end
            OP_RE: re_ff <= 34'(xi_ff) * 34'(pi_ff) + 34'(xq_ff) * 34'(pq_ff);
            OP_IM: begin
               im_ff <= 34'(xq_ff) * 34'(pi_ff) - 34'(xi_ff) * 34'(pq_ff);
               pi_ff <= xi_ff;
               pq_ff <= xq_ff;
            end
            OP_INIT: begin
               zero_ff <= (re_ff == '0) && (im_ff == '0);
               if (xe < 0) begin
                  cz_ff <= 32'h8000_0000;
                  cx_ff <= -xe;
                  cy_ff <= -ye;
               end else begin
                  cz_ff <= '0;
                  cx_ff <= xe;
                  cy_ff <= ye;
               end
            end
            OP_ROT: begin
               if (cy_ff >= 0) begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  cz_ff <= cz_ff + atan_lut(cmd.idx);
               end else begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  cz_ff <= cz_ff - atan_lut(cmd.idx);
               end
            end
            OP_SCALE: u_ff <= 32'((scale_p + 64'sd65536) >>> (SampleWidth + 1));
            OP_Y:     y_ff <= 50'(cmul(coef_b(3'd0), u_ff) + 64'(mem_ff[0]));
            OP_YF:    yf_ff <= 32'(yv);
            OP_FB_B:  t_ff <= cmul(coef_b(3'(cmd.idx[1:0]) + 3'd1), u_ff);
            OP_FB_A: begin
               // delay line shifts down, each new term entering at the top; after four steps it is back in order
               mem_ff[0] <= mem_ff[1];
               mem_ff[1] <= mem_ff[2];
               mem_ff[2] <= mem_ff[3];
               mem_ff[3] <= 48'(fb);
            end
            OP_OUT:   out_ff <= 16'(ov);
            default: ;
         endcase
      end
   end

   assign rsp_audio_sample = out_ff;

endmodule

// ===== rtl/core/nbfm_ctrl.sv =====
`timescale 1ns / 1ps
module nbfm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nbfm_pkg::cmd_type cmd
);
   import nbfm_pkg::*;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      cmd.idx      = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_RE;
            end
         end
         S_RE: begin
            cmd.op   = OP_RE;
            state_in = S_IM;
         end
         S_IM: begin
            cmd.op   = OP_IM;
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            cnt_in   = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            cmd.op = OP_ROT;
            if (cnt_ff == 5'(CordicSteps - 1)) begin
               cnt_in   = '0;
               state_in = S_SCALE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = S_Y;
         end
         S_Y: begin
            cmd.op   = OP_Y;
            state_in = S_YF;
         end
         S_YF: begin
            cmd.op   = OP_YF;
            cnt_in   = '0;
            state_in = S_FB_B;
         end
         S_FB_B: begin
            cmd.op   = OP_FB_B;
            state_in = S_FB_A;
         end
         S_FB_A: begin
            cmd.op = OP_FB_A;
            if (cnt_ff == 5'd3) begin
               state_in = S_OUT;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = S_FB_B;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_RE)
      else $error("accepted item did not start");
   a_rot_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROT |-> cnt_ff < 5'(CordicSteps))
      else $error("rotation count out of range");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && state_in == S_IDLE |=> rsp_valid_ff)
      else $error("finished item not presented");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_OUT |-> out_free)
      else $error("pending result overwritten");

endmodule
